// File: hw/rtl/zzcov_pkg.sv
// Zig-zag coverage navigator: package with widths, register indexes, reset values,
// heading windows and the navigation mode codes.
// Depends on nothing; imported by zigzag_coverage_navigator.
`timescale 1ns / 1ps

package zzcov_pkg;

    // Waypoint store limits.
    localparam int MAX_WAYPOINTS = 128;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int CMP_W         = 16;

    // Field widths.
    localparam int POS_W   = 20;
    localparam int HDG_W   = 13;
    localparam int AHDG_W  = HDG_W + 1;
    localparam int LANE_W  = 9;
    localparam int DRIVE_W = 11;
    localparam int MODE_W  = 4;

    localparam int HW_W    = 16;
    localparam int HL_W    = 17;
    localparam int SPACE_W = 13;
    localparam int WCNT_W  = 8;
    localparam int SPEED_W = 10;
    localparam int REACH_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier operand width and product width.
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_WIDTH  = 3'd0,
        CFG_HALF_LENGTH = 3'd1,
        CFG_LANE_SPACE  = 3'd2,
        CFG_WAYPT_COUNT = 3'd3,
        CFG_CRUISE      = 3'd4,
        CFG_REACH_SQ    = 3'd5
    } t_cfg_idx;

    localparam logic [HW_W-1:0]    RST_HALF_WIDTH  = 16'd4608;
    localparam logic [HL_W-1:0]    RST_HALF_LENGTH = 17'd9728;
    localparam logic [SPACE_W-1:0] RST_LANE_SPACE  = 13'd512;
    localparam logic [WCNT_W-1:0]  RST_WAYPT_COUNT = 8'd76;
    localparam logic [SPEED_W-1:0] RST_CRUISE      = 10'd102;
    localparam logic [REACH_W-1:0] RST_REACH_SQ    = 32'd1268777;

    // Lane direction in whole degrees.
    localparam logic signed [LANE_W-1:0] LANE_NORTH    = 9'sd90;
    localparam logic signed [LANE_W-1:0] LANE_SOUTH    = -9'sd90;
    localparam logic signed [LANE_W-1:0] LANE_N_LO     = 9'sd89;
    localparam logic signed [LANE_W-1:0] LANE_N_HI     = 9'sd91;
    localparam logic signed [LANE_W-1:0] LANE_S_LO     = -9'sd91;
    localparam logic signed [LANE_W-1:0] LANE_S_HI     = -9'sd89;

    // Heading windows in 1/16 degree.
    localparam logic signed [HDG_W-1:0] HDG_N_LO    = 13'sd1424;
    localparam logic signed [HDG_W-1:0] HDG_N_HI    = 13'sd1456;
    localparam logic signed [HDG_W-1:0] HDG_S_LO    = -13'sd1456;
    localparam logic signed [HDG_W-1:0] HDG_S_HI    = -13'sd1424;
    localparam logic [AHDG_W-1:0]       HDG_BACK_LO = 14'd2864;
    localparam logic [AHDG_W-1:0]       HDG_BACK_HI = 14'd2896;
    localparam logic signed [HDG_W-1:0] HDG_DIV_BIAS = 13'sd15;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT   = 4'd0,
        MODE_FWD    = 4'd1,
        MODE_PAUSE  = 4'd2,
        MODE_LEFT   = 4'd3,
        MODE_RIGHT  = 4'd4,
        MODE_UTR    = 4'd5,
        MODE_UTL    = 4'd6,
        MODE_UNUSED = 4'd7,
        MODE_DONE   = 4'd8
    } t_nav_mode;

endpackage

// File: hw/rtl/zigzag_coverage_navigator.sv
// Zig-zag coverage navigator: top level with sequencer, shared multiplier and mode logic.
// Depends on zzcov_pkg.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  in       | to block  | i_in_valid/o_in_stall | i_gps_x, i_gps_z, i_heading
//  out      | from block| o_out_valid/i_out_stall | o_left_drive, o_right_drive, o_mode,
//           |           |                      | o_target_number
//  cfg      | to block  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A tick is loaded into the output register in the final step of the sequencer, and the next
// transaction can be accepted once the sequencer has returned to idle: one multiplier is
// used four times in turn (waypoint z for the old index, dx squared, dz squared, waypoint z
// for the new index), with a subtract step before the squares and a compare step after them.
// The input stalls until the result has been loaded into the output register; a
// stalled output holds the sequencer in its last step until the register frees up.
// Reset (synchronous, active low) restores the registers to their defaults, the mode
// to init, the lane to north and the waypoint index to one.
`timescale 1ns / 1ps

module zigzag_coverage_navigator
    import zzcov_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [POS_W-1:0]   i_gps_x,
    input  logic signed [POS_W-1:0]   i_gps_z,
    input  logic signed [HDG_W-1:0]   i_heading,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DRIVE_W-1:0] o_left_drive,
    output logic signed [DRIVE_W-1:0] o_right_drive,
    output logic [MODE_W-1:0]         o_mode,
    output logic [IDX_W-1:0]          o_target_number,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZO,
        S_DIFF,
        S_SQX,
        S_SQZ,
        S_CMP,
        S_ZN,
        S_MODE
    } t_seq_state;

    t_seq_state r_state;

    // Configuration registers.
    logic [HW_W-1:0]    r_half_width;
    logic [HL_W-1:0]    r_half_length;
    logic [SPACE_W-1:0] r_lane_space;
    logic [WCNT_W-1:0]  r_waypt_count;
    logic [SPEED_W-1:0] r_cruise;
    logic [REACH_W-1:0] r_reach_sq;

    // Navigation state.
    t_nav_mode               r_mode;
    logic signed [LANE_W-1:0] r_lane;
    logic [IDX_W-1:0]         r_idx;

    // Working registers.
    logic signed [POS_W-1:0] r_gx;
    logic signed [POS_W-1:0] r_gz;
    logic signed [HDG_W-1:0] r_h;
    logic signed [MUL_W-1:0] r_dx;
    logic signed [MUL_W-1:0] r_dz;
    logic signed [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0]        r_acc;

    // Output register.
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_out_left;
    logic signed [DRIVE_W-1:0] r_out_right;
    logic [MODE_W-1:0]         r_out_mode;
    logic [IDX_W-1:0]          r_out_idx;

    logic                      in_take;
    logic                      out_free;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [CMP_W-1:0]          cnt;
    logic [CMP_W-1:0]          idx_plus;
    logic [PROD_W:0]           dist_sq;
    logic                      reached;
    logic signed [MUL_W-1:0]   wpx;
    logic signed [MUL_W-1:0]   wpz;
    logic signed [MUL_W-1:0]   gx_ext;
    logic signed [MUL_W-1:0]   gz_ext;
    logic signed [MUL_W-1:0]   hw_ext;
    logic signed [HDG_W-1:0]   h_biased;
    logic signed [HDG_W-1:0]   h_deg;
    logic signed [AHDG_W-1:0]  h_wide;
    logic [AHDG_W-1:0]         h_abs;
    logic                      lane_north;
    logic                      lane_south;
    logic                      facing_back;
    logic signed [DRIVE_W-1:0] spd_pos;
    logic signed [DRIVE_W-1:0] spd_neg;

    t_nav_mode                 n_mode;
    logic signed [LANE_W-1:0]  n_lane;
    logic signed [DRIVE_W-1:0] n_left;
    logic signed [DRIVE_W-1:0] n_right;

    assign in_take     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid     = r_out_valid;
    assign o_left_drive    = r_out_left;
    assign o_right_drive   = r_out_right;
    assign o_mode          = r_out_mode;
    assign o_target_number = r_out_idx;

    // Effective waypoint count, clamped to the supported range.
    always_comb begin
        cnt = CMP_W'(r_waypt_count);
        if (cnt < CMP_W'(2)) begin
            cnt = CMP_W'(2);
        end else if (cnt > CMP_W'(MAX_WAYPOINTS)) begin
            cnt = CMP_W'(MAX_WAYPOINTS);
        end
    end

    assign idx_plus = CMP_W'(r_idx) + CMP_W'(1);

    // Waypoint x is plus half_width when bit one of k+1 is set, i.e. k[1] xor k[0].
    assign hw_ext = $signed(MUL_W'(r_half_width));
    assign wpx    = (r_idx[1] ^ r_idx[0]) ? hw_ext : -hw_ext;
    assign wpz    = $signed(r_prod[MUL_W-1:0]) - $signed(MUL_W'(r_half_length));
    assign gx_ext = MUL_W'(r_gx);
    assign gz_ext = MUL_W'(r_gz);

    // The one multiplier of the block, shared by all four products of a tick.
    always_comb begin
        case (r_state)
            S_SQX: begin
                mul_a = r_dx;
                mul_b = r_dx;
            end
            S_SQZ: begin
                mul_a = r_dz;
                mul_b = r_dz;
            end
            default: begin
                mul_a = $signed(MUL_W'(r_lane_space));
                mul_b = $signed(MUL_W'(r_idx[IDX_W-1:1]));
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dist_sq = {1'b0, r_acc} + {1'b0, r_prod};
    assign reached = (dist_sq <= (PROD_W + 1)'(r_reach_sq));

    // Heading in whole degrees, truncated toward zero.
    assign h_biased = r_h[HDG_W-1] ? (r_h + HDG_DIV_BIAS) : r_h;
    assign h_deg    = h_biased >>> 4;
    assign h_wide   = AHDG_W'(r_h);
    assign h_abs    = h_wide[AHDG_W-1] ? AHDG_W'(-h_wide) : AHDG_W'(h_wide);

    assign lane_north  = (r_lane >= LANE_N_LO) && (r_lane <= LANE_N_HI);
    assign lane_south  = (r_lane >= LANE_S_LO) && (r_lane <= LANE_S_HI);
    assign facing_back = (h_abs >= HDG_BACK_LO) && (h_abs <= HDG_BACK_HI);

    assign spd_pos = $signed(DRIVE_W'(r_cruise));
    assign spd_neg = -spd_pos;

    // Mode transition; r_idx already holds the advanced index and r_prod its z term.
    always_comb begin
        n_mode  = r_mode;
        n_lane  = r_lane;
        n_left  = '0;
        n_right = '0;
        case (r_mode)
            MODE_INIT: begin
                n_lane = h_deg[LANE_W-1:0];
                n_mode = MODE_FWD;
            end
            MODE_FWD: begin
                n_left  = spd_pos;
                n_right = spd_pos;
                if (lane_north) begin
                    if (gx_ext >= wpx) n_mode = MODE_PAUSE;
                end else if (lane_south) begin
                    if (gx_ext <= wpx) n_mode = MODE_PAUSE;
                end else if (CMP_W'(r_idx) == cnt - CMP_W'(1)) begin
                    n_mode = MODE_DONE;
                end
            end
            MODE_PAUSE: begin
                if (lane_north) begin
                    n_mode = MODE_RIGHT;
                end else if (lane_south) begin
                    n_mode = MODE_LEFT;
                end
            end
            MODE_LEFT: begin
                n_left  = spd_neg;
                n_right = spd_pos;
                if (facing_back) begin
                    n_left  = spd_pos;
                    n_right = spd_pos;
                    if (gz_ext >= wpz && gx_ext <= wpx) n_mode = MODE_UTL;
                end
            end
            MODE_RIGHT: begin
                n_left  = spd_pos;
                n_right = spd_neg;
                if (facing_back) begin
                    n_left  = spd_pos;
                    n_right = spd_pos;
                    if (gz_ext >= wpz) n_mode = MODE_UTR;
                end
            end
            MODE_UTR: begin
                n_left  = spd_pos;
                n_right = spd_neg;
                if (r_h >= HDG_S_LO && r_h <= HDG_S_HI) begin
                    n_lane = LANE_SOUTH;
                    n_mode = MODE_FWD;
                end
            end
            MODE_UTL: begin
                n_left  = spd_neg;
                n_right = spd_pos;
                if (r_h >= HDG_N_LO && r_h <= HDG_N_HI) begin
                    n_lane = LANE_NORTH;
                    n_mode = MODE_FWD;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mode        <= MODE_INIT;
            r_lane        <= LANE_NORTH;
            r_idx         <= IDX_W'(1);
            r_out_valid   <= 1'b0;
            r_half_width  <= RST_HALF_WIDTH;
            r_half_length <= RST_HALF_LENGTH;
            r_lane_space  <= RST_LANE_SPACE;
            r_waypt_count <= RST_WAYPT_COUNT;
            r_cruise      <= RST_CRUISE;
            r_reach_sq    <= RST_REACH_SQ;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HALF_WIDTH:  r_half_width  <= i_cfg_data[HW_W-1:0];
                    CFG_HALF_LENGTH: r_half_length <= i_cfg_data[HL_W-1:0];
                    CFG_LANE_SPACE:  r_lane_space  <= i_cfg_data[SPACE_W-1:0];
                    CFG_WAYPT_COUNT: r_waypt_count <= i_cfg_data[WCNT_W-1:0];
                    CFG_CRUISE:      r_cruise      <= i_cfg_data[SPEED_W-1:0];
                    CFG_REACH_SQ:    r_reach_sq    <= i_cfg_data[REACH_W-1:0];
                    default: ;
                endcase
            end

            // In the final step the output register is handled by the load below.
            if (r_out_valid && !i_out_stall && (r_state != S_MODE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_gx    <= i_gps_x;
                        r_gz    <= i_gps_z;
                        r_h     <= i_heading;
                        r_state <= S_ZO;
                    end
                end
                S_ZO: begin
                    r_prod  <= mul_p;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_dx    <= wpx - gx_ext;
                    r_dz    <= wpz - gz_ext;
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_prod  <= mul_p;
                    r_state <= S_SQZ;
                end
                S_SQZ: begin
                    r_acc   <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (reached && idx_plus < cnt) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                    r_state <= S_ZN;
                end
                S_ZN: begin
                    r_prod  <= mul_p;
                    r_state <= S_MODE;
                end
                S_MODE: begin
                    // The tick commits only once the output register can take it.
                    if (out_free) begin
                        r_mode      <= n_mode;
                        r_lane      <= n_lane;
                        r_out_valid <= 1'b1;
                        r_out_left  <= n_left;
                        r_out_right <= n_right;
                        r_out_mode  <= n_mode;
                        r_out_idx   <= r_idx;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_idx != $past(r_idx)))
            |-> ((r_idx == $past(r_idx) + 1'b1) && ($past(r_state) == S_CMP)))
        else $error("waypoint index moved by other than one step, or outside the compare step");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_out_valid && !$past(r_out_valid))
            |-> ($past(r_state) == S_MODE))
        else $error("result loaded outside the final step");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == S_ZO))
        else $error("accepted transaction did not start the sequence");

    a_mode_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MODE) && out_free) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("final step did not load the output register");

endmodule
